@@ rtl/cle_pkg.sv @@
package cle_pkg;

  localparam int POS_W = 6;

  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_ESCAPE    = 8'd27;
  localparam logic [7:0] KEY_BACKSPACE = 8'd127;
  localparam logic [7:0] KEY_CTRL_W    = 8'd23;
  localparam logic [7:0] KEY_CTRL_A    = 8'd1;
  localparam logic [7:0] KEY_CTRL_E    = 8'd5;
  localparam logic [7:0] KEY_TAB       = 8'd9;
  localparam logic [7:0] KEY_LEFT      = 8'd68;
  localparam logic [7:0] KEY_RIGHT     = 8'd67;
  localparam logic [7:0] CHAR_QMARK    = 8'd63;
  localparam logic [7:0] CHAR_SPACE    = 8'd32;

  localparam logic [7:0] THRESHOLD_RESET = 8'd31;

  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [7:0]       fill;
  } cell_ctrl_t;

endpackage

@@ rtl/cle_key_if.sv @@
interface cle_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;

  modport source (output valid, output key_byte, input ready);
  modport sink (input valid, input key_byte, output ready);
endinterface

@@ rtl/cle_line_if.sv @@
interface cle_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_char;
  logic       line_last;
  logic       line_empty;
  logic       overflow_seen;

  modport source (output valid, output line_char, output line_last, output line_empty,
                  output overflow_seen, input ready);
  modport sink (input valid, input line_char, input line_last, input line_empty,
                input overflow_seen, output ready);
endinterface

@@ rtl/cle_cell.sv @@
module cle_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  cle_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          from_left,
  input  logic [7:0]          from_right,
  output logic [7:0]          data,
  output logic                space_hit
);

  localparam logic [cle_pkg::POS_W-1:0] IDX_C = cle_pkg::POS_W'(IDX);

  assign space_hit = (IDX_C == ctrl.pos) && (data == cle_pkg::CHAR_SPACE);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      cle_pkg::OP_INS: begin
        if (IDX_C > ctrl.pos) begin
          data <= from_left;
        end else if (IDX_C == ctrl.pos) begin
          data <= ctrl.fill;
        end
      end
      cle_pkg::OP_DEL: begin
        if (IDX_C >= ctrl.pos) begin
          data <= from_right;
        end
      end
      default: begin
        data <= data;
      end
    endcase
  end

endmodule

@@ rtl/console_line_editor_core.sv @@
// Edit keys and cursor moves are applied from the idle state; Ctrl-W then deletes bytes before
// the cursor one at a time until it meets a space or the line head.
// Newline: bytes leave from cell 0 through the output register, one byte per cycle unless the
// output stalls, as the cell row shifts one place toward the head; an empty line gives one beat.
// Throughput: one key per cycle for edit keys; none is taken during Ctrl-W deletion or line output.
// Reset: synchronous rst clears length, cursor, escape state, overflow flag, threshold (31)
// and the output valid; cell contents are not reset.
module console_line_editor_core #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  cle_key_if.sink           key,
  cle_line_if.source        line
);

  localparam int LEN_W = $clog2(LINE_CAPACITY + 1);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WDEL  = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  logic [1:0]       state, state_next;
  logic [LEN_W-1:0] length, length_next;
  logic [LEN_W-1:0] cursor, cursor_next;
  logic [1:0]       esc_phase, esc_phase_next;
  logic             dropped, dropped_next;
  logic [7:0]       threshold;

  logic             out_valid;
  logic [7:0]       out_char;
  logic             out_last;
  logic             out_empty;
  logic             out_ovf;

  logic             can_load;
  logic             load;
  logic [7:0]       load_char;
  logic             load_last;
  logic             load_empty;

  cle_pkg::cell_ctrl_t       ctrl;
  logic [7:0]                cell_q [LINE_CAPACITY];
  logic [LINE_CAPACITY-1:0]  hits;
  logic                      space_any;

  for (genvar g = 0; g < LINE_CAPACITY; g++) begin : g_cell
    logic [7:0] left_d;
    logic [7:0] right_d;
    if (g == 0) begin : g_head
      assign left_d = 8'd0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == LINE_CAPACITY - 1) begin : g_tail
      assign right_d = 8'd0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    cle_cell #(.IDX(g)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_left  (left_d),
      .from_right (right_d),
      .data       (cell_q[g]),
      .space_hit  (hits[g])
    );
  end

  assign space_any = |hits;
  assign key.ready = (state == ST_IDLE);
  assign can_load  = !out_valid || line.ready;

  assign line.valid         = out_valid;
  assign line.line_char     = out_char;
  assign line.line_last     = out_last;
  assign line.line_empty    = out_empty;
  assign line.overflow_seen = out_ovf;

  always_comb begin
    state_next     = state;
    length_next    = length;
    cursor_next    = cursor;
    esc_phase_next = esc_phase;
    dropped_next   = dropped;
    ctrl           = '{op: cle_pkg::OP_HOLD, pos: '0, fill: 8'd0};
    load           = 1'b0;
    load_char      = 8'd0;
    load_last      = 1'b0;
    load_empty     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (key.valid) begin
          if (esc_phase == 2'd1) begin
            esc_phase_next = 2'd2;
          end else if (esc_phase == 2'd2) begin
            esc_phase_next = 2'd0;
            if (key.key_byte == cle_pkg::KEY_LEFT && cursor != '0) begin
              cursor_next = cursor - ONE;
            end else if (key.key_byte == cle_pkg::KEY_RIGHT && cursor < length) begin
              cursor_next = cursor + ONE;
            end
          end else begin
            case (key.key_byte)
              cle_pkg::KEY_NEWLINE: begin
                cursor_next = '0;
                state_next  = (length == '0) ? ST_EMPTY : ST_EMIT;
              end
              cle_pkg::KEY_ESCAPE: begin
                esc_phase_next = 2'd1;
              end
              cle_pkg::KEY_BACKSPACE: begin
                if (cursor != '0) begin
                  ctrl.op     = cle_pkg::OP_DEL;
                  ctrl.pos    = cle_pkg::POS_W'(cursor - ONE);
                  cursor_next = cursor - ONE;
                  length_next = length - ONE;
                end
              end
              cle_pkg::KEY_CTRL_W: begin
                state_next = ST_WDEL;
              end
              cle_pkg::KEY_CTRL_A: begin
                cursor_next = '0;
              end
              cle_pkg::KEY_CTRL_E: begin
                cursor_next = length;
              end
              cle_pkg::KEY_TAB: begin
                cursor_next = cursor;
              end
              default: begin
                if (length >= CAP) begin
                  dropped_next = 1'b1;
                end else begin
                  ctrl.op     = cle_pkg::OP_INS;
                  ctrl.pos    = cle_pkg::POS_W'(cursor);
                  ctrl.fill   = (key.key_byte <= threshold) ? cle_pkg::CHAR_QMARK
                                                            : key.key_byte;
                  cursor_next = cursor + ONE;
                  length_next = length + ONE;
                end
              end
            endcase
          end
        end
      end
      ST_WDEL: begin
        ctrl.pos = cle_pkg::POS_W'(cursor - ONE);
        if (cursor != '0 && cursor <= length && !space_any) begin
          ctrl.op     = cle_pkg::OP_DEL;
          cursor_next = cursor - ONE;
          length_next = length - ONE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          ctrl.op     = cle_pkg::OP_DEL;
          ctrl.pos    = '0;
          load        = 1'b1;
          load_char   = cell_q[0];
          load_last   = (length == ONE);
          length_next = length - ONE;
          if (length == ONE) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMPTY: begin
        if (can_load) begin
          load       = 1'b1;
          load_last  = 1'b1;
          load_empty = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      length    <= '0;
      cursor    <= '0;
      esc_phase <= 2'd0;
      dropped   <= 1'b0;
      threshold <= cle_pkg::THRESHOLD_RESET;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      length    <= length_next;
      cursor    <= cursor_next;
      esc_phase <= esc_phase_next;
      dropped   <= dropped_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (line.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= load_char;
      out_last  <= load_last;
      out_empty <= load_empty;
      out_ovf   <= dropped;
    end
  end

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    cursor <= length)
    else $error("cursor beyond line length");

  a_length_in_cap: assert property (@(posedge clk) disable iff (rst)
    length <= CAP)
    else $error("line length beyond capacity");

  a_newline_homes: assert property (@(posedge clk) disable iff (rst)
    (key.valid && key.ready && esc_phase == 2'd0 && key.key_byte == cle_pkg::KEY_NEWLINE)
    |=> (cursor == '0 && (state == ST_EMIT || state == ST_EMPTY)))
    else $error("newline did not start line output");

endmodule

@@ dv/tb_console_line_editor_core.sv @@
`timescale 1ns / 100ps

module tb_console_line_editor_core;

  localparam int LINE_CAP      = 64;
  localparam int SETTLE_CYCLES = 2 * LINE_CAP + 8;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 100;

  typedef struct packed {
    logic [7:0] line_char;
    logic       line_last;
    logic       line_empty;
    logic       overflow_seen;
  } line_beat_t;

  typedef enum logic [1:0] {ESC_IDLE, ESC_SWALLOW, ESC_FINAL} esc_state_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  cle_key_if  key_ch ();
  cle_line_if line_ch ();

  console_line_editor_core #(
    .LINE_CAPACITY(LINE_CAP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .key      (key_ch),
    .line     (line_ch)
  );

  logic [7:0] model_line [LINE_CAP];
  int         model_len;
  int         model_cursor;
  esc_state_t model_esc;
  logic       model_dropped;
  logic [7:0] model_threshold;

  line_beat_t line_expected [$];
  line_beat_t want_beat;
  int         fail_count = 0;
  int         items_sent;
  int         cycle_count = 0;
  int         key_gap_pct;
  int         ready_gap_pct;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    line_ch.ready <= !rst && ($urandom_range(99) >= ready_gap_pct);
    if (!rst && line_ch.valid && line_ch.ready) begin
      if (line_expected.size() == 0) begin
        $error("unexpected line transaction, line_char %0d", line_ch.line_char);
        fail_count++;
      end else begin
        want_beat = line_expected.pop_front();
        if (line_ch.line_char !== want_beat.line_char) begin
          $error("line_char expected %0d actual %0d", want_beat.line_char, line_ch.line_char);
          fail_count++;
        end
        if (line_ch.line_last !== want_beat.line_last) begin
          $error("line_last expected %0d actual %0d", want_beat.line_last, line_ch.line_last);
          fail_count++;
        end
        if (line_ch.line_empty !== want_beat.line_empty) begin
          $error("line_empty expected %0d actual %0d", want_beat.line_empty,
                 line_ch.line_empty);
          fail_count++;
        end
        if (line_ch.overflow_seen !== want_beat.overflow_seen) begin
          $error("overflow_seen expected %0d actual %0d", want_beat.overflow_seen,
                 line_ch.overflow_seen);
          fail_count++;
        end
      end
    end
  end

  task automatic erase_prev_char();
    if (model_cursor == 0) return;
    for (int i = model_cursor; i < model_len; i++) model_line[i-1] = model_line[i];
    model_cursor--;
    model_len--;
  endtask

  task automatic insert_char(input logic [7:0] c);
    if (model_len >= LINE_CAP) begin
      model_dropped = 1'b1;
      return;
    end
    for (int i = model_len; i > model_cursor; i--) model_line[i] = model_line[i-1];
    model_line[model_cursor] = c;
    model_len++;
    model_cursor++;
  endtask

  task automatic predict_key(input logic [7:0] b);
    if (model_esc == ESC_SWALLOW) begin
      model_esc = ESC_FINAL;
    end else if (model_esc == ESC_FINAL) begin
      model_esc = ESC_IDLE;
      if (b == cle_pkg::KEY_LEFT && model_cursor > 0) model_cursor--;
      else if (b == cle_pkg::KEY_RIGHT && model_cursor < model_len) model_cursor++;
    end else begin
      case (b)
        cle_pkg::KEY_NEWLINE: begin
          if (model_len == 0) begin
            line_expected.push_back('{8'd0, 1'b1, 1'b1, model_dropped});
          end else begin
            for (int i = 0; i < model_len; i++)
              line_expected.push_back('{model_line[i], (i == model_len - 1), 1'b0,
                                         model_dropped});
          end
          model_len = 0;
          model_cursor = 0;
        end
        cle_pkg::KEY_ESCAPE: model_esc = ESC_SWALLOW;
        cle_pkg::KEY_BACKSPACE: erase_prev_char();
        cle_pkg::KEY_CTRL_W: begin
          while (model_cursor > 0 && model_line[model_cursor-1] != cle_pkg::CHAR_SPACE)
            erase_prev_char();
        end
        cle_pkg::KEY_CTRL_A: model_cursor = 0;
        cle_pkg::KEY_CTRL_E: model_cursor = model_len;
        cle_pkg::KEY_TAB: ;
        default: insert_char((b <= model_threshold) ? cle_pkg::CHAR_QMARK : b);
      endcase
    end
  endtask

  task automatic send_key(input logic [7:0] b);
    if ($urandom_range(99) < key_gap_pct) begin
      key_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < key_gap_pct) @(posedge clk);
    end
    key_ch.valid    <= 1'b1;
    key_ch.key_byte <= b;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    predict_key(b);
    items_sent++;
  endtask

  task automatic drain_line();
    key_ch.valid <= 1'b0;
    while (line_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [7:0] value);
    drain_line();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_threshold = value;
  endtask

  task automatic send_random_key();
    int pick;
    int sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(99);
    if (pick < 45) begin
      if (sub < 10) send_key(cle_pkg::CHAR_SPACE);
      else if (sub < 80) send_key(8'($urandom_range(33, 126)));
      else send_key(8'($urandom_range(128, 255)));
    end else if (pick < 53) send_key(cle_pkg::KEY_BACKSPACE);
    else if (pick < 57) send_key(cle_pkg::KEY_CTRL_W);
    else if (pick < 61) send_key(cle_pkg::KEY_CTRL_A);
    else if (pick < 65) send_key(cle_pkg::KEY_CTRL_E);
    else if (pick < 78) begin
      send_key(cle_pkg::KEY_ESCAPE);
      send_key(8'($urandom_range(0, 255)));
      if (sub < 40) send_key(cle_pkg::KEY_LEFT);
      else if (sub < 80) send_key(cle_pkg::KEY_RIGHT);
      else send_key(8'($urandom_range(0, 255)));
    end else if (pick < 80) send_key(cle_pkg::KEY_TAB);
    else if (pick < 84) send_key(8'($urandom_range(0, 255)));
    else if (pick < 88) begin
      send_key(cle_pkg::KEY_ESCAPE);
      if (sub < 50) send_key(cle_pkg::KEY_NEWLINE);
    end else send_key(8'($urandom_range(11, 31)));
  endtask

  task automatic send_random_line();
    int n_keys;
    n_keys = ($urandom_range(9) == 0) ? $urandom_range(20, 56) : $urandom_range(0, 12);
    repeat (n_keys) send_random_key();
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  task automatic test_empty_line();
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  task automatic test_edit_keys();
    send_key(8'd97);
    send_key(8'd98);
    send_key(8'd99);
    send_key(cle_pkg::KEY_CTRL_A);
    send_key(8'd120);
    send_key(cle_pkg::KEY_CTRL_E);
    send_key(cle_pkg::KEY_BACKSPACE);
    send_key(cle_pkg::KEY_TAB);
    send_key(8'd0);
    send_key(8'd255);
    send_key(8'd126);
    send_key(cle_pkg::CHAR_SPACE);
    send_key(cle_pkg::THRESHOLD_RESET);
    send_key(cle_pkg::KEY_ESCAPE);
    send_key(8'd120);
    send_key(cle_pkg::KEY_LEFT);
    send_key(cle_pkg::KEY_ESCAPE);
    send_key(cle_pkg::KEY_NEWLINE);
    send_key(cle_pkg::KEY_RIGHT);
    send_key(cle_pkg::KEY_ESCAPE);
    send_key(cle_pkg::KEY_CTRL_A);
    send_key(8'd122);
    send_key(8'd119);
    send_key(cle_pkg::KEY_CTRL_W);
    send_key(cle_pkg::KEY_CTRL_W);
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  task automatic test_cursor_bounds();
    send_key(cle_pkg::KEY_BACKSPACE);
    send_key(cle_pkg::KEY_CTRL_W);
    send_key(cle_pkg::KEY_ESCAPE);
    send_key(8'd0);
    send_key(cle_pkg::KEY_LEFT);
    send_key(8'd65);
    send_key(cle_pkg::KEY_ESCAPE);
    send_key(8'd91);
    send_key(cle_pkg::KEY_RIGHT);
    send_key(cle_pkg::KEY_CTRL_A);
    send_key(cle_pkg::KEY_BACKSPACE);
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  task automatic test_threshold();
    write_threshold(8'd0);
    send_key(8'd0);
    send_key(8'd31);
    send_key(8'd128);
    write_threshold(8'd255);
    send_key(8'd65);
    send_key(8'd254);
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  task automatic test_random_phase(input int key_pct, input int ready_pct,
                                   input logic [7:0] thr);
    int start_count;
    write_threshold(thr);
    key_gap_pct   = key_pct;
    ready_gap_pct = ready_pct;
    start_count   = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) send_random_line();
  endtask

  task automatic test_full_line();
    write_threshold(cle_pkg::THRESHOLD_RESET);
    repeat (LINE_CAP + 3) send_key(8'($urandom_range(33, 126)));
    send_key(cle_pkg::KEY_BACKSPACE);
    send_key(8'd66);
    send_key(8'd67);
    send_key(cle_pkg::KEY_NEWLINE);
    send_key(8'd122);
    send_key(cle_pkg::KEY_NEWLINE);
    send_key(cle_pkg::KEY_NEWLINE);
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 8'd0;
    key_ch.valid    <= 1'b0;
    key_ch.key_byte <= 8'd0;
    model_len       = 0;
    model_cursor    = 0;
    model_esc       = ESC_IDLE;
    model_dropped   = 1'b0;
    model_threshold = cle_pkg::THRESHOLD_RESET;
    items_sent      = 0;
    key_gap_pct     = 35;
    ready_gap_pct   = 66;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_line();
    test_edit_keys();
    test_cursor_bounds();
    test_threshold();
    test_random_phase(35, 66, 8'($urandom_range(0, 255)));
    test_random_phase(66, 35, 8'd255);
    test_random_phase(0, 0, cle_pkg::THRESHOLD_RESET);
    test_full_line();
    drain_line();

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cle_pkg.sv
rtl/cle_key_if.sv
rtl/cle_line_if.sv
rtl/cle_cell.sv
rtl/console_line_editor_core.sv
dv/tb_console_line_editor_core.sv
